>>> design/mrdc_pkg.sv
// ----------------------------------------------------------------------------
// mrdc_pkg
// Shared types, constants and the CRC-16 byte update for the Modbus RTU
// digital I/O response checker.
// ----------------------------------------------------------------------------
package mrdc_pkg;

    localparam int unsigned IDX_W = 5;

    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [7:0]  DEV_ADDR_RESET = 8'd1;
    localparam logic [7:0]  FUNC_READ      = 8'd1;
    localparam logic [7:0]  FUNC_WRITE     = 8'd15;
    localparam logic [7:0]  READ_COUNT     = 8'd12;
    localparam logic [7:0]  ECHO_LAST      = 8'd31;
    localparam logic [7:0]  ECHO_ZERO      = 8'd0;

    localparam logic [IDX_W-1:0] READ_LEN   = 5'd17;
    localparam logic [IDX_W-1:0] WRITE_LEN  = 5'd8;
    localparam logic [IDX_W-1:0] IDX_ADDR   = 5'd0;
    localparam logic [IDX_W-1:0] IDX_FUNC   = 5'd1;
    localparam logic [IDX_W-1:0] IDX_COUNT  = 5'd2;
    localparam logic [IDX_W-1:0] IDX_ECHO_L = 5'd5;

    typedef enum logic [2:0] {
        ST_READ_OK  = 3'd0,
        ST_WRITE_OK = 3'd1,
        ST_ADDR     = 3'd2,
        ST_FUNC     = 3'd3,
        ST_COUNT    = 3'd4,
        ST_ECHO     = 3'd5,
        ST_CRC      = 3'd6
    } t_status;

    typedef struct packed {
        logic        valid;
        t_status     status;
        logic [31:0] output_bits;
        logic [31:0] input_bits;
    } t_step_res;

    // Reflected CRC-16, one byte: eight shift-xor steps.
    function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {8'd0, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> design/mrdc_in_if.sv
// ----------------------------------------------------------------------------
// mrdc_in_if
// Byte channel into the checker: one received reply byte per word.
// ----------------------------------------------------------------------------
interface mrdc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

>>> design/mrdc_out_if.sv
// ----------------------------------------------------------------------------
// mrdc_out_if
// Result channel out of the checker: one status word per finished frame.
// ----------------------------------------------------------------------------
interface mrdc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] output_bits;
    logic [31:0] input_bits;

    modport source (output valid, output status, output output_bits, output input_bits,
                    input ready);
    modport sink   (input valid, input status, input output_bits, input input_bits,
                    output ready);
endinterface

>>> design/mrdc_frame.sv
// ----------------------------------------------------------------------------
// mrdc_frame
// Frame state and per-byte checking: address, function, byte count or echo,
// data capture and running CRC. The result for the presented byte is formed
// combinationally; state advances on i_step.
// ----------------------------------------------------------------------------
module mrdc_frame (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [7:0]           i_cfg_wr_data,
    input  logic                 i_byte_valid,
    input  logic [7:0]           i_byte,
    input  logic                 i_start,
    input  logic                 i_step,
    output mrdc_pkg::t_step_res  o_res
);

    logic [7:0]                 r_dev_addr;
    logic [mrdc_pkg::IDX_W-1:0] r_idx,  n_idx,  e_idx;
    logic [15:0]                r_crc,  n_crc,  e_crc;
    logic                       r_kind, n_kind, e_kind;
    logic [7:0]                 r_low,  n_low,  e_low;
    logic [31:0]                r_coil, n_coil, e_coil;
    logic [31:0]                r_inw,  n_inw,  e_inw;
    logic                       r_ign,  n_ign,  e_ign;

    logic [mrdc_pkg::IDX_W-1:0] len;
    logic [15:0]                got;
    logic [7:0]                 want;
    logic                       fin;
    logic                       crc_upd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= mrdc_pkg::DEV_ADDR_RESET;
        end else if (i_cfg_wr_en) begin
            r_dev_addr <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_crc  <= mrdc_pkg::CRC_INIT;
            r_kind <= 1'b0;
            r_low  <= '0;
            r_coil <= '0;
            r_inw  <= '0;
            r_ign  <= 1'b1;
        end else if (i_step) begin
            r_idx  <= n_idx;
            r_crc  <= n_crc;
            r_kind <= n_kind;
            r_low  <= n_low;
            r_coil <= n_coil;
            r_inw  <= n_inw;
            r_ign  <= n_ign;
        end
    end

    always_comb begin
        // A first byte restarts the frame before it is checked.
        if (i_start) begin
            e_idx  = '0;
            e_crc  = mrdc_pkg::CRC_INIT;
            e_kind = 1'b0;
            e_low  = '0;
            e_coil = '0;
            e_inw  = '0;
            e_ign  = 1'b0;
        end else begin
            e_idx  = r_idx;
            e_crc  = r_crc;
            e_kind = r_kind;
            e_low  = r_low;
            e_coil = r_coil;
            e_inw  = r_inw;
            e_ign  = r_ign;
        end

        n_idx  = e_idx;
        n_crc  = e_crc;
        n_kind = e_kind;
        n_low  = e_low;
        n_coil = e_coil;
        n_inw  = e_inw;
        n_ign  = e_ign;

        len     = e_kind ? mrdc_pkg::WRITE_LEN : mrdc_pkg::READ_LEN;
        got     = {i_byte, e_low};
        want    = (e_idx == mrdc_pkg::IDX_ECHO_L) ? mrdc_pkg::ECHO_LAST : mrdc_pkg::ECHO_ZERO;
        fin     = 1'b0;
        crc_upd = 1'b1;

        o_res.valid       = 1'b0;
        o_res.status      = mrdc_pkg::ST_READ_OK;
        o_res.output_bits = '0;
        o_res.input_bits  = '0;

        if (!e_ign) begin
            if (e_idx == mrdc_pkg::IDX_ADDR) begin
                if (i_byte != r_dev_addr) begin
                    fin          = 1'b1;
                    o_res.status = mrdc_pkg::ST_ADDR;
                end
            end else if (e_idx == mrdc_pkg::IDX_FUNC) begin
                if (i_byte == mrdc_pkg::FUNC_READ) begin
                    n_kind = 1'b0;
                end else if (i_byte == mrdc_pkg::FUNC_WRITE) begin
                    n_kind = 1'b1;
                end else begin
                    fin          = 1'b1;
                    o_res.status = mrdc_pkg::ST_FUNC;
                end
            end else if (e_idx == len - 5'd2) begin
                n_low   = i_byte;
                crc_upd = 1'b0;
            end else if (e_idx >= len - 5'd1) begin
                fin = 1'b1;
                if (got != e_crc) begin
                    o_res.status = mrdc_pkg::ST_CRC;
                end else if (e_kind) begin
                    o_res.status = mrdc_pkg::ST_WRITE_OK;
                end else begin
                    o_res.status      = mrdc_pkg::ST_READ_OK;
                    o_res.output_bits = e_coil;
                    o_res.input_bits  = e_inw;
                end
            end else if (e_kind) begin
                if (i_byte != want) begin
                    fin          = 1'b1;
                    o_res.status = mrdc_pkg::ST_ECHO;
                end
            end else begin
                if (e_idx == mrdc_pkg::IDX_COUNT && i_byte != mrdc_pkg::READ_COUNT) begin
                    fin          = 1'b1;
                    o_res.status = mrdc_pkg::ST_COUNT;
                end
                case (e_idx)
                    5'd3:    n_coil[7:0]   = e_coil[7:0]   | i_byte;
                    5'd4:    n_coil[15:8]  = e_coil[15:8]  | i_byte;
                    5'd5:    n_coil[23:16] = e_coil[23:16] | i_byte;
                    5'd6:    n_coil[31:24] = e_coil[31:24] | i_byte;
                    5'd9:    n_inw[7:0]    = e_inw[7:0]    | i_byte;
                    5'd10:   n_inw[15:8]   = e_inw[15:8]   | i_byte;
                    5'd11:   n_inw[23:16]  = e_inw[23:16]  | i_byte;
                    5'd12:   n_inw[31:24]  = e_inw[31:24]  | i_byte;
                    default: ;
                endcase
            end

            if (fin) begin
                n_ign = 1'b1;
            end else begin
                if (crc_upd) begin
                    n_crc = mrdc_pkg::crc_byte(e_crc, i_byte);
                end
                n_idx = e_idx + 5'd1;
            end
            o_res.valid = fin & i_byte_valid;
        end
    end

endmodule

>>> design/modbus_rtu_dio_response_checker.sv
// ----------------------------------------------------------------------------
// modbus_rtu_dio_response_checker
// Checks a Modbus RTU reply of a 32-bit digital I/O board byte by byte and
// reports one status word per finished or failed frame.
// ----------------------------------------------------------------------------
// The checker takes one reply byte per clock cycle. Each byte is registered and
// checked combinationally against the frame state; a result, when the byte ends
// the frame or breaks it, is written to the result register as the byte leaves
// the input register. The input stops only when the result register still holds
// a word the sink has not taken and the byte waiting in the input register would
// produce another one; otherwise a byte is accepted every cycle.
module modbus_rtu_dio_response_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    mrdc_in_if.sink    i_byte_ch,
    mrdc_out_if.source o_result_ch
);

    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_in_start;

    logic                r_out_valid;
    logic [2:0]          r_out_status;
    logic [31:0]         r_out_obits;
    logic [31:0]         r_out_ibits;

    mrdc_pkg::t_step_res res;
    logic                out_free;
    logic                advance;
    logic                in_ready;

    assign out_free = !r_out_valid || o_result_ch.ready;
    assign advance  = r_in_valid && (!res.valid || out_free);
    assign in_ready = !r_in_valid || advance;

    assign i_byte_ch.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_byte_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_byte_ch.valid) begin
            r_in_byte  <= i_byte_ch.rx_byte;
            r_in_start <= i_byte_ch.frame_start;
        end
    end

    mrdc_frame u_frame (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_byte_valid  (r_in_valid),
        .i_byte        (r_in_byte),
        .i_start       (r_in_start),
        .i_step        (advance),
        .o_res         (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && res.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_result_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res.valid) begin
            r_out_status <= res.status;
            r_out_obits  <= res.output_bits;
            r_out_ibits  <= res.input_bits;
        end
    end

    assign o_result_ch.valid       = r_out_valid;
    assign o_result_ch.status      = r_out_status;
    assign o_result_ch.output_bits = r_out_obits;
    assign o_result_ch.input_bits  = r_out_ibits;

endmodule

>>> design/mrdc_checker.sv
// ----------------------------------------------------------------------------
// mrdc_checker
// Port-level assertions for the response checker, bound to the top level.
// ----------------------------------------------------------------------------
module mrdc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_out_status,
    input logic [31:0] i_out_obits,
    input logic [31:0] i_out_ibits
);

    // Reset empties the result register.
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // With no result pending, the byte input never stalls.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result register");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_status <= mrdc_pkg::ST_CRC))
        else $error("status out of range");

    // Only a good read reply carries data bits.
    a_bits_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_status != mrdc_pkg::ST_READ_OK)
            |-> (i_out_obits == 32'd0 && i_out_ibits == 32'd0))
        else $error("data bits set on a non-read result");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_status)))
        else $error("stalled result changed");

endmodule

bind modbus_rtu_dio_response_checker mrdc_checker u_mrdc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_byte_ch.ready),
    .i_out_valid  (o_result_ch.valid),
    .i_out_ready  (o_result_ch.ready),
    .i_out_status (o_result_ch.status),
    .i_out_obits  (o_result_ch.output_bits),
    .i_out_ibits  (o_result_ch.input_bits)
);
